// ----- rtl/core/vpn_pkg.sv -----
// Package: widths, stage counts and latency of the vector pair normalizer.
package vpn_pkg;

   localparam int COMP_W     = 24;             // input and output component width
   localparam int MAG_W      = 24;             // magnitude of a component, up to 2^23
   localparam int SUM_W      = 48;             // exact sum of three squares
   localparam int ROOT_W     = 46;             // floor(sqrt(s * 2^44)) < 2^46
   localparam int SQRT_REM_W = ROOT_W + 3;     // partial remainder of the root recurrence
   localparam int SQRT_STEPS = ROOT_W;         // one result bit per stage
   localparam int QUO_W      = 23;             // quotient magnitude up to 2^22
   localparam int DIV_STEPS  = QUO_W;          // one quotient bit per stage
   localparam int DIV_REM_W  = ROOT_W + 1;     // partial remainder stays below 2 * q
   localparam int DIV_PRESHIFT = 44 - QUO_W;   // dividend bits above the quotient window
   localparam int FRONT_STAGES = 3;            // magnitude, square, sum
   localparam int LATENCY    = FRONT_STAGES + SQRT_STEPS + DIV_STEPS + 1;

   // Side data that rides along with the root: zero flag, signs, magnitudes.
   typedef struct packed {
      logic                   zero;
      logic [2:0]             neg;
      logic [2:0][MAG_W-1:0]  mag;
   } side_type;

endpackage

// ----- rtl/core/vpn_sqrt.sv -----
// Pipelined integer square root of s * 2^44, one root bit per stage.
module vpn_sqrt (
   input  logic                         clock,
   input  logic [vpn_pkg::SUM_W-1:0]    sum_in,
   input  vpn_pkg::side_type            side_in,
   output logic [vpn_pkg::ROOT_W-1:0]   root_out,
   output vpn_pkg::side_type            side_out
);
   import vpn_pkg::*;

   logic [SUM_W-1:0]      rad_ff  [SQRT_STEPS];
   logic [SQRT_REM_W-1:0] rem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0]     root_ff [SQRT_STEPS];
   side_type              side_ff [SQRT_STEPS];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      logic [SUM_W-1:0]      rad_cur;
      logic [SQRT_REM_W-1:0] rem_cur;
      logic [ROOT_W-1:0]     root_cur;
      side_type              side_cur;
      logic [SQRT_REM_W-1:0] rem_sh;
      logic [SQRT_REM_W-1:0] trial;

      if (i == 0) begin : g_first
         assign rad_cur  = sum_in;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign side_cur = side_in;
      end else begin : g_next
         assign rad_cur  = rad_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign root_cur = root_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      // bring down the next two radicand bits (zeros once s is used up)
      assign rem_sh = {rem_cur[SQRT_REM_W-3:0], rad_cur[SUM_W-1 -: 2]};
      assign trial  = {{(SQRT_REM_W-ROOT_W-2){1'b0}}, root_cur, 2'b01};

      always_ff @(posedge clock) begin
         rad_ff[i]  <= {rad_cur[SUM_W-3:0], 2'b00};
         side_ff[i] <= side_cur;
         if (rem_sh >= trial) begin
            rem_ff[i]  <= rem_sh - trial;
            root_ff[i] <= {root_cur[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[i]  <= rem_sh;
            root_ff[i] <= {root_cur[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign root_out = root_ff[SQRT_STEPS-1];
   assign side_out = side_ff[SQRT_STEPS-1];

endmodule

// ----- rtl/core/vpn_div.sv -----
// Pipelined restoring divider: trunc(mag * 2^44 / q), signed result.
module vpn_div (
   input  logic                              clock,
   input  logic [vpn_pkg::ROOT_W-1:0]        q_in,
   input  logic [vpn_pkg::MAG_W-1:0]         mag_in,
   input  logic                              neg_in,
   input  logic                              zero_in,
   output logic signed [vpn_pkg::COMP_W-1:0] unit_out
);
   import vpn_pkg::*;

   logic [DIV_REM_W-1:0]     rem_ff  [DIV_STEPS];
   logic [QUO_W-1:0]         quo_ff  [DIV_STEPS];
   logic [ROOT_W-1:0]        q_ff    [DIV_STEPS];
   logic                     neg_ff  [DIV_STEPS];
   logic                     zero_ff [DIV_STEPS];
   logic signed [COMP_W-1:0] unit_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [DIV_REM_W-1:0] rem_cur;
      logic [QUO_W-1:0]     quo_cur;
      logic [ROOT_W-1:0]    q_cur;
      logic                 neg_cur;
      logic                 zero_cur;
      logic [DIV_REM_W-1:0] rem_sh;
      logic [DIV_REM_W-1:0] q_ext;

      if (i == 0) begin : g_first
         // mag * 2^21 < q, so the upper quotient bits are all zero
         assign rem_cur  = {{(DIV_REM_W-MAG_W-DIV_PRESHIFT){1'b0}}, mag_in,
                            {DIV_PRESHIFT{1'b0}}};
         assign quo_cur  = '0;
         assign q_cur    = q_in;
         assign neg_cur  = neg_in;
         assign zero_cur = zero_in;
      end else begin : g_next
         assign rem_cur  = rem_ff[i-1];
         assign quo_cur  = quo_ff[i-1];
         assign q_cur    = q_ff[i-1];
         assign neg_cur  = neg_ff[i-1];
         assign zero_cur = zero_ff[i-1];
      end

      assign rem_sh = {rem_cur[DIV_REM_W-2:0], 1'b0};
      assign q_ext  = {1'b0, q_cur};

      always_ff @(posedge clock) begin
         q_ff[i]    <= q_cur;
         neg_ff[i]  <= neg_cur;
         zero_ff[i] <= zero_cur;
         if (rem_sh >= q_ext) begin
            rem_ff[i] <= rem_sh - q_ext;
            quo_ff[i] <= {quo_cur[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff[i] <= rem_sh;
            quo_ff[i] <= {quo_cur[QUO_W-2:0], 1'b0};
         end
      end
   end

   // apply sign; a zero-length vector forces zero
   logic [COMP_W-1:0] quo_ext;
   assign quo_ext = {{(COMP_W-QUO_W){1'b0}}, quo_ff[DIV_STEPS-1]};

   always_ff @(posedge clock) begin
      if (zero_ff[DIV_STEPS-1]) begin
         unit_ff <= '0;
      end else if (neg_ff[DIV_STEPS-1]) begin
         unit_ff <= -$signed(quo_ext);
      end else begin
         unit_ff <= $signed(quo_ext);
      end
   end

   assign unit_out = unit_ff;

endmodule

// ----- rtl/core/vpn_norm3.sv -----
// One 3-component normalizer: squares, sum, root, three dividers.
module vpn_norm3 (
   input  logic                              clock,
   input  logic signed [vpn_pkg::COMP_W-1:0] x_in,
   input  logic signed [vpn_pkg::COMP_W-1:0] y_in,
   input  logic signed [vpn_pkg::COMP_W-1:0] z_in,
   output logic signed [vpn_pkg::COMP_W-1:0] x_out,
   output logic signed [vpn_pkg::COMP_W-1:0] y_out,
   output logic signed [vpn_pkg::COMP_W-1:0] z_out,
   output logic                              zero_out
);
   import vpn_pkg::*;

   logic signed [COMP_W-1:0] comp [3];
   logic [MAG_W-1:0]   mag_ff [3];
   logic [2:0]         neg_ff;
   logic [SUM_W-1:0]   sq_ff  [3];
   logic [MAG_W-1:0]   mag2_ff [3];
   logic [2:0]         neg2_ff;
   logic [SUM_W-1:0]   sum_ff;
   side_type           side_ff;
   logic [ROOT_W-1:0]  root;
   side_type           side_root;
   logic               zero_d_ff [DIV_STEPS+1];

   assign comp[0] = x_in;
   assign comp[1] = y_in;
   assign comp[2] = z_in;

   // stage 1: magnitude and sign; stage 2: squares
   for (genvar k = 0; k < 3; k++) begin : g_comp
      always_ff @(posedge clock) begin
         mag_ff[k]  <= comp[k][COMP_W-1] ? MAG_W'(-comp[k]) : MAG_W'(comp[k]);
         neg_ff[k]  <= comp[k][COMP_W-1];
         sq_ff[k]   <= mag_ff[k] * mag_ff[k];
         mag2_ff[k] <= mag_ff[k];
         neg2_ff[k] <= neg_ff[k];
      end
   end

   // stage 3: exact sum of squares
   always_ff @(posedge clock) begin
      sum_ff       <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      side_ff.zero <= (sq_ff[0] == '0) && (sq_ff[1] == '0) && (sq_ff[2] == '0);
      side_ff.neg  <= neg2_ff;
      side_ff.mag  <= {mag2_ff[2], mag2_ff[1], mag2_ff[0]};
   end

   vpn_sqrt u_sqrt (
      .clock    (clock),
      .sum_in   (sum_ff),
      .side_in  (side_ff),
      .root_out (root),
      .side_out (side_root)
   );

   vpn_div u_div_x (
      .clock (clock), .q_in (root), .mag_in (side_root.mag[0]),
      .neg_in (side_root.neg[0]), .zero_in (side_root.zero), .unit_out (x_out)
   );
   vpn_div u_div_y (
      .clock (clock), .q_in (root), .mag_in (side_root.mag[1]),
      .neg_in (side_root.neg[1]), .zero_in (side_root.zero), .unit_out (y_out)
   );
   vpn_div u_div_z (
      .clock (clock), .q_in (root), .mag_in (side_root.mag[2]),
      .neg_in (side_root.neg[2]), .zero_in (side_root.zero), .unit_out (z_out)
   );

   // zero flag delayed to line up with the divider outputs
   for (genvar i = 0; i < DIV_STEPS + 1; i++) begin : g_zero
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            zero_d_ff[i] <= side_root.zero;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            zero_d_ff[i] <= zero_d_ff[i-1];
         end
      end
   end

   assign zero_out = zero_d_ff[DIV_STEPS];

endmodule

// ----- rtl/core/vector_pair_normalizer.sv -----
// Top level: normalizes the two vectors of one catalogue object per cycle.
//
// Each transaction carries vectors a and b (signed 24-bit components) and
// yields both scaled to unit length, 1.0 = 4194304, with a zero flag for a
// zero-length vector. busy is always low: a new transaction is taken every
// cycle and the result appears with rsp_valid high; the receiver cannot
// stall. The pipeline is made of the pipelined square root (46 stages, one
// root bit each) and the pipelined divider (23 stages, one quotient bit
// each), plus three front stages for the magnitudes, the squares and their
// sum, and one output stage.
module vector_pair_normalizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [vpn_pkg::COMP_W-1:0] req_a_x,
   input  logic signed [vpn_pkg::COMP_W-1:0] req_a_y,
   input  logic signed [vpn_pkg::COMP_W-1:0] req_a_z,
   input  logic signed [vpn_pkg::COMP_W-1:0] req_b_x,
   input  logic signed [vpn_pkg::COMP_W-1:0] req_b_y,
   input  logic signed [vpn_pkg::COMP_W-1:0] req_b_z,
   output logic                              rsp_valid,
   output logic signed [vpn_pkg::COMP_W-1:0] rsp_unit_a_x,
   output logic signed [vpn_pkg::COMP_W-1:0] rsp_unit_a_y,
   output logic signed [vpn_pkg::COMP_W-1:0] rsp_unit_a_z,
   output logic signed [vpn_pkg::COMP_W-1:0] rsp_unit_b_x,
   output logic signed [vpn_pkg::COMP_W-1:0] rsp_unit_b_y,
   output logic signed [vpn_pkg::COMP_W-1:0] rsp_unit_b_z,
   output logic                              rsp_a_is_zero,
   output logic                              rsp_b_is_zero
);
   import vpn_pkg::*;

   logic [LATENCY-1:0] valid_ff;
   logic [LATENCY-1:0] valid_in;

   assign busy = 1'b0;

   // valid bit per pipeline stage
   assign valid_in = {valid_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LATENCY-1];

   vpn_norm3 u_norm_a (
      .clock    (clock),
      .x_in     (req_a_x), .y_in (req_a_y), .z_in (req_a_z),
      .x_out    (rsp_unit_a_x), .y_out (rsp_unit_a_y), .z_out (rsp_unit_a_z),
      .zero_out (rsp_a_is_zero)
   );

   vpn_norm3 u_norm_b (
      .clock    (clock),
      .x_in     (req_b_x), .y_in (req_b_y), .z_in (req_b_z),
      .x_out    (rsp_unit_b_x), .y_out (rsp_unit_b_y), .z_out (rsp_unit_b_z),
      .zero_out (rsp_b_is_zero)
   );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the vector pair normalizer.
`timescale 1ns / 100ps

module tb_top;
   import vpn_pkg::*;

   typedef logic [COMP_W-1:0] comp_type;

   // Expected result of one transaction
   typedef struct {
      comp_type unit[6];
      logic     a_zero;
      logic     b_zero;
   } unit_pair_type;

   // Predicts normalized vectors and holds them until the block delivers them
   class unit_scoreboard;
      unit_pair_type pending_units[$];
      int            mismatches;
      int            checked;
      int            zero_hits;

      function new();
         mismatches = 0;
         checked    = 0;
         zero_hits  = 0;
      endfunction

      function automatic logic [MAG_W-1:0] magnitude(comp_type c);
         return c[COMP_W-1] ? MAG_W'(-$signed(c)) : c;
      endfunction

      // floor(sqrt(s * 2^44)), bit by bit from the top
      function automatic logic [47:0] scaled_root(logic [SUM_W-1:0] s);
         logic [95:0] target;
         logic [47:0] root;
         logic [47:0] trial;
         target = {48'd0, s} << 44;
         root   = '0;
         for (int b = 47; b >= 0; b--) begin
            trial = root | (48'd1 << b);
            if ({48'd0, trial} * {48'd0, trial} <= target) root = trial;
         end
         return root;
      endfunction

      // Normalize one 3-vector; returns the zero flag
      function automatic logic unit_vector(input comp_type c[3], output comp_type u[3]);
         logic [SUM_W-1:0] sum_sq;
         logic [47:0]      q;
         logic [67:0]      num;
         logic [67:0]      quo;
         sum_sq = '0;
         for (int k = 0; k < 3; k++)
            sum_sq += {24'd0, magnitude(c[k])} * {24'd0, magnitude(c[k])};
         if (sum_sq == '0) begin
            for (int k = 0; k < 3; k++) u[k] = '0;
            return 1'b1;
         end
         q = scaled_root(sum_sq);
         for (int k = 0; k < 3; k++) begin
            num  = {44'd0, magnitude(c[k])} << 44;
            quo  = num / {20'd0, q};
            u[k] = c[k][COMP_W-1] ? comp_type'(-quo) : comp_type'(quo);
         end
         return 1'b0;
      endfunction

      // Note one accepted transaction and queue its expected result
      function void note_input(comp_type req[6]);
         unit_pair_type e;
         comp_type va[3], vb[3], ua[3], ub[3];
         for (int k = 0; k < 3; k++) begin
            va[k] = req[k];
            vb[k] = req[k+3];
         end
         e.a_zero = unit_vector(va, ua);
         e.b_zero = unit_vector(vb, ub);
         for (int k = 0; k < 3; k++) begin
            e.unit[k]   = ua[k];
            e.unit[k+3] = ub[k];
         end
         if (e.a_zero || e.b_zero) zero_hits++;
         pending_units = {pending_units, e};
      endfunction

      function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH t=%0t %s: got %0h expected %0h", $time, what, got, want);
         mismatches++;
      endfunction

      // Compare one delivered result with the oldest expectation
      function void check_result(comp_type rsp[6], logic a_zero, logic b_zero);
         unit_pair_type e;
         if (pending_units.size() == 0) begin
            report_mismatch("unexpected result", 32'd0, 32'd0);
            return;
         end
         e = pending_units.pop_front();
         checked++;
         for (int k = 0; k < 6; k++)
            if (rsp[k] !== e.unit[k])
               report_mismatch($sformatf("unit[%0d]", k), 32'(rsp[k]), 32'(e.unit[k]));
         if (a_zero !== e.a_zero) report_mismatch("a_is_zero", 32'(a_zero), 32'(e.a_zero));
         if (b_zero !== e.b_zero) report_mismatch("b_is_zero", 32'(b_zero), 32'(e.b_zero));
      endfunction
   endclass

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   comp_type req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z;
   logic     rsp_valid;
   comp_type rsp_unit_a_x, rsp_unit_a_y, rsp_unit_a_z;
   comp_type rsp_unit_b_x, rsp_unit_b_y, rsp_unit_b_z;
   logic     rsp_a_is_zero, rsp_b_is_zero;

   unit_scoreboard sb = new();
   int             cycle_count = 0;
   int             sender_idle_pct;

   localparam int CYCLE_LIMIT = 200000;

   vector_pair_normalizer u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_a_x       (req_a_x),
      .req_a_y       (req_a_y),
      .req_a_z       (req_a_z),
      .req_b_x       (req_b_x),
      .req_b_y       (req_b_y),
      .req_b_z       (req_b_z),
      .rsp_valid     (rsp_valid),
      .rsp_unit_a_x  (rsp_unit_a_x),
      .rsp_unit_a_y  (rsp_unit_a_y),
      .rsp_unit_a_z  (rsp_unit_a_z),
      .rsp_unit_b_x  (rsp_unit_b_x),
      .rsp_unit_b_y  (rsp_unit_b_y),
      .rsp_unit_b_z  (rsp_unit_b_z),
      .rsp_a_is_zero (rsp_a_is_zero),
      .rsp_b_is_zero (rsp_b_is_zero)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Monitor: accepted transactions and delivered results, plus watchdog
   always @(posedge clock) begin
      comp_type req[6];
      comp_type rsp[6];
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_top: done, errors");
         $finish;
      end else if (!reset) begin
         if (start && !busy) begin
            req = '{req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z};
            sb.note_input(req);
         end
         if (rsp_valid) begin
            rsp = '{rsp_unit_a_x, rsp_unit_a_y, rsp_unit_a_z,
                    rsp_unit_b_x, rsp_unit_b_y, rsp_unit_b_z};
            sb.check_result(rsp, rsp_a_is_zero, rsp_b_is_zero);
         end
      end
   end

   // Present one transaction; each cycle the sender may idle first
   task automatic send_vectors(comp_type ax, comp_type ay, comp_type az,
                               comp_type bx, comp_type by, comp_type bz);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start   <= 1'b1;
      req_a_x <= ax;
      req_a_y <= ay;
      req_a_z <= az;
      req_b_x <= bx;
      req_b_y <= by;
      req_b_z <= bz;
      // busy only moves at the rising edge, so look mid-cycle
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
   endtask

   // Random component with a spread of magnitudes
   function automatic comp_type rand_comp();
      case ($urandom_range(9))
         0:       return '0;
         1:       return comp_type'($signed($urandom_range(0, 6)) - 3);
         2:       return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         3, 4:    return comp_type'($signed($urandom_range(0, 8191)) - 4096);
         default: return comp_type'($urandom);
      endcase
   endfunction

   task automatic send_random_pair();
      comp_type v[6];
      for (int k = 0; k < 6; k++) v[k] = rand_comp();
      // zero vectors on either side now and then
      if ($urandom_range(15) == 0) for (int k = 0; k < 3; k++) v[k] = '0;
      if ($urandom_range(15) == 0) for (int k = 3; k < 6; k++) v[k] = '0;
      send_vectors(v[0], v[1], v[2], v[3], v[4], v[5]);
   endtask

   initial begin
      int limit_wait;
      sender_idle_pct = 0;
      reset   = 1'b1;
      start   = 1'b0;
      req_a_x = '0;
      req_a_y = '0;
      req_a_z = '0;
      req_b_x = '0;
      req_b_y = '0;
      req_b_z = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero vectors, extremes, axes, tiny and mixed signs
      send_vectors(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
      send_vectors(24'h0, 24'h0, 24'h0, 24'h1, 24'h0, 24'h0);
      send_vectors(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
      send_vectors(24'h800000, 24'h0, 24'h0, 24'h0, 24'h800000, 24'h0);
      send_vectors(24'h0, 24'h0, 24'h800000, 24'h7FFFFF, 24'h0, 24'h0);
      send_vectors(24'h1, 24'h0, 24'h0, 24'h0, 24'h1, 24'h0);
      send_vectors(24'h0, 24'h0, 24'h1, 24'hFFFFFF, 24'h0, 24'h0);
      send_vectors(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h1, 24'h1, 24'h1);
      send_vectors(24'h3, 24'h4, 24'h0, 24'h0, 24'hFFFFFD, 24'hFFFFFC);
      send_vectors(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h1);
      send_vectors(24'h400000, 24'h0, 24'h0, 24'h0, 24'h0, 24'hC00000);
      send_vectors(24'h1, 24'h7FFFFF, 24'h0, 24'h800000, 24'h1, 24'hFFFFFF);
      send_vectors(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 24'hF0F0F0, 24'h333333, 24'hCCCCCC);
      send_vectors(24'h2, 24'h2, 24'h1, 24'h000100, 24'h000100, 24'h000100);

      // Random: sender idles 33 percent, then 71 percent, then back to back
      sender_idle_pct = 33;
      repeat (350) send_random_pair();
      sender_idle_pct = 71;
      repeat (350) send_random_pair();
      sender_idle_pct = 0;
      repeat (350) send_random_pair();
      start <= 1'b0;

      // Drain the pipeline
      limit_wait = 0;
      while (sb.pending_units.size() != 0 && limit_wait < 20 * LATENCY) begin
         @(posedge clock);
         limit_wait++;
      end
      repeat (LATENCY + 10) @(posedge clock);

      if (sb.pending_units.size() != 0)
         sb.report_mismatch("results never delivered", 32'(sb.pending_units.size()), 32'd0);
      $display("checked %0d transactions, %0d with a zero-length vector",
               sb.checked, sb.zero_hits);
      $display("covered extremes, axes, tiny vectors, sparse and dense input streams");
      if (sb.mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/vpn_pkg.sv
rtl/core/vpn_sqrt.sv
rtl/core/vpn_div.sv
rtl/core/vpn_norm3.sv
rtl/core/vector_pair_normalizer.sv
dv/tb_top.sv
